[rtl/rrsf_pkg.sv]
package rrsf_pkg;

    // default geometry widths
    localparam int COORD_BITS  = 12;
    localparam int RADIUS_BITS = 11;

    // colour formats
    localparam int COLOR_BITS = 24;
    localparam int PIXEL_BITS = 16;

    // entries in the job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // what the back end has to do with one row
    typedef enum logic [1:0] {
        KIND_EMPTY,
        KIND_FULL,
        KIND_ARC
    } t_kind;

    // back end sequencer
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SQUARE,
        BK_PROD,
        BK_WIDE,
        BK_SUM,
        BK_SEARCH,
        BK_DONE
    } t_back_state;

    // job record at the default widths
    typedef struct packed {
        t_kind                   kind;
        logic [COORD_BITS-1:0]   clip_left;
        logic [COORD_BITS-1:0]   clip_right;
        logic [COORD_BITS:0]     cx;
        logic [COORD_BITS-1:0]   dx;
        logic                    ex;
        logic [RADIUS_BITS-1:0]  rx;
        logic [RADIUS_BITS-1:0]  ry;
        logic [RADIUS_BITS-1:0]  y;
        logic [PIXEL_BITS-1:0]   pixel;
    } t_job;

endpackage

[rtl/rrsf_if.sv]
// request channel: one row query per transfer
interface rrsf_in_if #(
    parameter int COORD_BITS  = rrsf_pkg::COORD_BITS,
    parameter int RADIUS_BITS = rrsf_pkg::RADIUS_BITS
);
    logic                            valid;
    logic                            ready;
    logic [COORD_BITS-1:0]           target_left;
    logic [COORD_BITS-1:0]           target_top;
    logic [COORD_BITS-1:0]           target_right;
    logic [COORD_BITS-1:0]           target_bottom;
    logic [COORD_BITS-1:0]           clip_left;
    logic [COORD_BITS-1:0]           clip_top;
    logic [COORD_BITS-1:0]           clip_right;
    logic [COORD_BITS-1:0]           clip_bottom;
    logic [RADIUS_BITS-1:0]          corner_radius;
    logic [rrsf_pkg::COLOR_BITS-1:0] color_rgb;
    logic [COORD_BITS-1:0]           row;

    modport source (
        output valid, target_left, target_top, target_right, target_bottom,
               clip_left, clip_top, clip_right, clip_bottom, corner_radius,
               color_rgb, row,
        input  ready
    );
    modport sink (
        input  valid, target_left, target_top, target_right, target_bottom,
               clip_left, clip_top, clip_right, clip_bottom, corner_radius,
               color_rgb, row,
        output ready
    );
endinterface

// result channel: one span per transfer
interface rrsf_out_if #(
    parameter int COORD_BITS = rrsf_pkg::COORD_BITS
);
    logic                            valid;
    logic                            ready;
    logic                            draw;
    logic [COORD_BITS-1:0]           span_start;
    logic [COORD_BITS-1:0]           span_end;
    logic [rrsf_pkg::PIXEL_BITS-1:0] pixel;

    modport source (output valid, draw, span_start, span_end, pixel, input ready);
    modport sink (input valid, draw, span_start, span_end, pixel, output ready);
endinterface

[rtl/rrsf_front.sv]
module rrsf_front #(
    parameter int  COORD_BITS  = rrsf_pkg::COORD_BITS,
    parameter int  RADIUS_BITS = rrsf_pkg::RADIUS_BITS,
    parameter type t_job       = rrsf_pkg::t_job
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rrsf_in_if.sink   i_in,
    output t_job      o_job,
    output logic      o_push,
    input  logic      i_full
);

    localparam int CB = COORD_BITS;
    localparam int RB = RADIUS_BITS;
    localparam int CW = ((RB + 1) > CB) ? (RB + 1) : CB;
    localparam int SW = ((CB > RB) ? CB : RB) + 3;

    // stage register
    logic                        r_v1;
    logic [CB-1:0]               r_cl, r_cr, r_ct, r_cb, r_row;
    logic                        r_rad_zero;
    logic [CB:0]                 r_cx, r_cy;
    logic [CB-1:0]               r_dx, r_dy;
    logic [RB-1:0]               r_rx, r_ry;
    logic                        r_ex, r_fy;
    logic [rrsf_pkg::PIXEL_BITS-1:0] r_pixel;

    logic          w_take;
    logic [CB-1:0] w_w, w_h;
    logic [CB-2:0] w_hw, w_hh;
    logic          w_fit_x, w_fit_y;

    // handshake: the stage frees up when its job goes into the queue
    assign o_push     = r_v1 && !i_full;
    assign i_in.ready = !r_v1 || !i_full;
    assign w_take     = i_in.valid && i_in.ready;

    // extents, inverted edges give zero
    assign w_w  = (i_in.target_right >= i_in.target_left) ?
                  (i_in.target_right - i_in.target_left) : '0;
    assign w_h  = (i_in.target_bottom >= i_in.target_top) ?
                  (i_in.target_bottom - i_in.target_top) : '0;
    assign w_hw = w_w[CB-1:1];
    assign w_hh = w_h[CB-1:1];

    // does the full radius fit in each direction
    assign w_fit_x = CW'({i_in.corner_radius, 1'b0}) <= CW'(w_w);
    assign w_fit_y = CW'({i_in.corner_radius, 1'b0}) <= CW'(w_h);

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_take) begin
            r_v1 <= 1'b1;
        end else if (o_push) begin
            r_v1 <= 1'b0;
        end
    end

    // geometry of the accepted item
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cl       <= i_in.clip_left;
            r_cr       <= i_in.clip_right;
            r_ct       <= i_in.clip_top;
            r_cb       <= i_in.clip_bottom;
            r_row      <= i_in.row;
            r_rad_zero <= (i_in.corner_radius == '0);
            r_cx       <= (CB+1)'(i_in.target_left) + (CB+1)'(w_hw);
            r_cy       <= (CB+1)'(i_in.target_top) + (CB+1)'(w_hh);
            r_rx       <= w_fit_x ? i_in.corner_radius : RB'(w_hw);
            r_ry       <= w_fit_y ? i_in.corner_radius : RB'(w_hh);
            r_dx       <= w_fit_x ? CB'(CW'(w_hw) - CW'(i_in.corner_radius)) : '0;
            r_dy       <= w_fit_y ? CB'(CW'(w_hh) - CW'(i_in.corner_radius)) : '0;
            r_ex       <= w_w[0];
            r_fy       <= !w_h[0];
            r_pixel    <= {i_in.color_rgb[23:19], i_in.color_rgb[15:10],
                           i_in.color_rgb[7:3]};
        end
    end

    // row classification
    logic [CB+1:0]        w_mid_lo, w_mid_hi, w_row_x;
    logic                 w_in_rows, w_mid;
    logic signed [SW-1:0] w_yu, w_yl, w_ry_s;
    logic                 w_yu_ok, w_yl_ok;

    assign w_in_rows = (r_row >= r_ct) && (r_row < r_cb);
    assign w_mid_lo  = (CB+2)'(r_cy) - (CB+2)'(r_dy);
    assign w_mid_hi  = (CB+2)'(r_cy) + (CB+2)'(r_dy);
    assign w_row_x   = (CB+2)'(r_row);
    assign w_mid     = (w_row_x >= w_mid_lo) && (w_row_x <= w_mid_hi);

    assign w_ry_s  = $signed(SW'(r_ry));
    assign w_yu    = $signed(SW'(w_mid_lo)) - $signed(SW'(w_row_x));
    assign w_yl    = $signed(SW'(w_row_x)) -
                     ($signed(SW'(w_mid_hi)) - $signed(SW'(r_fy)));
    assign w_yu_ok = (w_yu > 0) && (w_yu <= w_ry_s);
    assign w_yl_ok = (w_yl > 0) && (w_yl <= w_ry_s);

    // job for the back end
    always_comb begin
        o_job            = '0;
        o_job.clip_left  = r_cl;
        o_job.clip_right = r_cr;
        o_job.cx         = r_cx;
        o_job.dx         = r_dx;
        o_job.ex         = r_ex;
        o_job.rx         = r_rx;
        o_job.ry         = r_ry;
        o_job.pixel      = r_pixel;
        o_job.y          = w_yu_ok ? RB'(w_yu) : (w_yl_ok ? RB'(w_yl) : '0);
        if (!w_in_rows) begin
            o_job.kind = rrsf_pkg::KIND_EMPTY;
        end else if (r_rad_zero || w_mid) begin
            o_job.kind = rrsf_pkg::KIND_FULL;
        end else if (w_yu_ok || w_yl_ok) begin
            o_job.kind = rrsf_pkg::KIND_ARC;
        end else begin
            o_job.kind = rrsf_pkg::KIND_EMPTY;
        end
    end

endmodule

[rtl/rrsf_queue.sv]
module rrsf_queue #(
    parameter int  DEPTH = rrsf_pkg::QUEUE_DEPTH,
    parameter type t_job = rrsf_pkg::t_job
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [NW-1:0] r_count;

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

[rtl/rrsf_back.sv]
module rrsf_back #(
    parameter int  COORD_BITS  = rrsf_pkg::COORD_BITS,
    parameter int  RADIUS_BITS = rrsf_pkg::RADIUS_BITS,
    parameter type t_job       = rrsf_pkg::t_job
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_job        i_job,
    output logic        o_pop,
    rrsf_out_if.source  o_out
);

    localparam int CB = COORD_BITS;
    localparam int RB = RADIUS_BITS;
    localparam int EW = CB + 3;

    rrsf_pkg::t_back_state r_state, n_state;

    t_job            r_job;
    logic [2*RB-1:0] r_rx2, r_ry2, r_y2, r_dd, r_rym, r_rysh;
    logic [3*RB-1:0] r_h;
    logic [4*RB-1:0] r_t1;
    logic [4*RB:0]   r_lim;
    logic [RB-1:0]   r_m, r_bit;

    logic                        r_ov, r_draw;
    logic [CB-1:0]               r_start, r_end;
    logic [rrsf_pkg::PIXEL_BITS-1:0] r_pixel;

    logic            w_load;
    logic [RB-1:0]   w_cand;
    logic [2*RB-1:0] w_p;
    logic [4*RB-1:0] w_sq;
    logic            w_keep;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rrsf_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        w_load  = 1'b0;
        case (r_state)
            rrsf_pkg::BK_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = (i_job.kind == rrsf_pkg::KIND_ARC) ?
                              rrsf_pkg::BK_SQUARE : rrsf_pkg::BK_DONE;
                end
            end
            rrsf_pkg::BK_SQUARE: n_state = rrsf_pkg::BK_PROD;
            rrsf_pkg::BK_PROD:   n_state = rrsf_pkg::BK_WIDE;
            rrsf_pkg::BK_WIDE:   n_state = rrsf_pkg::BK_SUM;
            rrsf_pkg::BK_SUM:    n_state = rrsf_pkg::BK_SEARCH;
            rrsf_pkg::BK_SEARCH: begin
                if (r_bit[0]) begin
                    n_state = rrsf_pkg::BK_DONE;
                end
            end
            rrsf_pkg::BK_DONE: begin
                if (!r_ov || o_out.ready) begin
                    w_load  = 1'b1;
                    n_state = rrsf_pkg::BK_IDLE;
                end
            end
            default: n_state = rrsf_pkg::BK_IDLE;
        endcase
    end

    // one bit of the half-width per cycle, msb first
    assign w_cand = r_m | r_bit;
    assign w_p    = r_rym + r_rysh;
    assign w_sq   = w_p * w_p;
    assign w_keep = (w_cand <= r_job.rx) && ((4*RB+1)'(w_sq) <= r_lim);

    // arc arithmetic: limit minus row term, then the search
    always_ff @(posedge i_clk) begin
        case (r_state)
            rrsf_pkg::BK_IDLE: begin
                if (!i_empty) begin
                    r_job <= i_job;
                    r_m   <= '0;
                end
            end
            rrsf_pkg::BK_SQUARE: begin
                r_rx2 <= (2*RB)'(r_job.rx) * (2*RB)'(r_job.rx);
                r_ry2 <= (2*RB)'(r_job.ry) * (2*RB)'(r_job.ry);
                r_y2  <= (2*RB)'(r_job.y) * (2*RB)'(r_job.y);
            end
            rrsf_pkg::BK_PROD: begin
                r_dd <= r_ry2 - r_y2;
                r_h  <= (3*RB)'(r_rx2) * (3*RB)'(r_job.ry);
            end
            rrsf_pkg::BK_WIDE: begin
                r_t1 <= (4*RB)'(r_rx2) * (4*RB)'(r_dd);
            end
            rrsf_pkg::BK_SUM: begin
                r_lim  <= (4*RB+1)'(r_t1) + (4*RB+1)'(r_h >> 1);
                r_m    <= '0;
                r_rym  <= '0;
                r_bit  <= {1'b1, {(RB-1){1'b0}}};
                r_rysh <= (2*RB)'(r_job.ry) << (RB - 1);
            end
            rrsf_pkg::BK_SEARCH: begin
                if (w_keep) begin
                    r_m   <= w_cand;
                    r_rym <= w_p;
                end
                r_bit  <= r_bit >> 1;
                r_rysh <= r_rysh >> 1;
            end
            default: ;
        endcase
    end

    // span of the finished job, clipped
    logic [EW-1:0] w_s_raw, w_e_raw, w_s, w_e, w_cl, w_cr;
    logic          w_draw;

    assign w_cl = EW'(r_job.clip_left);
    assign w_cr = EW'(r_job.clip_right);

    always_comb begin
        w_s_raw = EW'(r_job.cx) - EW'(r_m) - EW'(r_job.dx);
        w_e_raw = EW'(r_job.cx) + EW'(r_m) + EW'(r_job.dx) + EW'(r_job.ex);
        case (r_job.kind)
            rrsf_pkg::KIND_FULL: begin
                w_s = w_cl;
                w_e = w_cr;
            end
            rrsf_pkg::KIND_ARC: begin
                w_s = (w_s_raw < w_cl) ? w_cl : w_s_raw;
                w_e = (w_e_raw > w_cr) ? w_cr : w_e_raw;
            end
            default: begin
                w_s = '0;
                w_e = '0;
            end
        endcase
        w_draw = (w_s < w_e);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_draw  <= w_draw;
            r_start <= w_draw ? CB'(w_s) : '0;
            r_end   <= w_draw ? CB'(w_e) : '0;
            r_pixel <= r_job.pixel;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.draw       = r_draw;
    assign o_out.span_start = r_start;
    assign o_out.span_end   = r_end;
    assign o_out.pixel      = r_pixel;

endmodule

[rtl/rounded_rect_span_fill.sv]
// Rounded rectangle span fill.
// i_in carries one row query per transfer: target rectangle, clip rectangle,
// corner radius, 24-bit colour and row. o_out returns one span per query, in
// order: draw flag, first column, column after the last, and RGB565 colour.
// Both channels move a transfer when valid and ready are high at a clock edge.
// The front stage registers the geometry and sorts the row into empty, full
// clip width or corner arc; a two-entry queue feeds the back end.
// In the back end, empty and full rows go from IDLE straight to DONE. Arc
// rows pass SQUARE, PROD, WIDE and SUM, which build the arc limit with
// registered multiplies, then SEARCH tests a candidate for one bit of the
// half-width per cycle with a single squarer. A query passes the front stage
// register, the queue, the back-end job register and the output register.
// Synchronous active-low reset empties the pipeline, the queue and the
// output register. A stalled receiver holds the result in the output
// register; the front keeps taking queries until the queue fills.
module rounded_rect_span_fill #(
    parameter int COORD_BITS  = rrsf_pkg::COORD_BITS,
    parameter int RADIUS_BITS = rrsf_pkg::RADIUS_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rrsf_in_if.sink     i_in,
    rrsf_out_if.source  o_out
);

    // job record at this instance's widths
    typedef struct packed {
        rrsf_pkg::t_kind                  kind;
        logic [COORD_BITS-1:0]            clip_left;
        logic [COORD_BITS-1:0]            clip_right;
        logic [COORD_BITS:0]              cx;
        logic [COORD_BITS-1:0]            dx;
        logic                             ex;
        logic [RADIUS_BITS-1:0]           rx;
        logic [RADIUS_BITS-1:0]           ry;
        logic [RADIUS_BITS-1:0]           y;
        logic [rrsf_pkg::PIXEL_BITS-1:0]  pixel;
    } t_job_p;

    t_job_p w_push_job, w_pop_job;
    logic   w_push, w_full, w_pop, w_empty;

    // classify
    rrsf_front #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS),
        .t_job       (t_job_p)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_job   (w_push_job),
        .o_push  (w_push),
        .i_full  (w_full)
    );

    // decoupling queue
    rrsf_queue #(
        .DEPTH (rrsf_pkg::QUEUE_DEPTH),
        .t_job (t_job_p)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_job   (w_pop_job),
        .o_empty (w_empty)
    );

    // arc search and span output
    rrsf_back #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS),
        .t_job       (t_job_p)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_job   (w_pop_job),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

    // queue never written while full nor read while empty
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("job queue read while empty");

    // a drawn span is never empty
    a_span_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.draw) |-> (o_out.span_start < o_out.span_end))
        else $error("drawn span is empty");

    // an undrawn row reports a zero span
    a_span_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.draw) |->
            (o_out.span_start == '0 && o_out.span_end == '0))
        else $error("undrawn row with nonzero span");

endmodule

[tb/sv/rounded_rect_span_fill_test.sv]
module rounded_rect_span_fill_test;

    localparam int COORD_BITS  = rrsf_pkg::COORD_BITS;
    localparam int RADIUS_BITS = rrsf_pkg::RADIUS_BITS;
    localparam int COLOR_BITS  = rrsf_pkg::COLOR_BITS;
    localparam int PIXEL_BITS  = rrsf_pkg::PIXEL_BITS;

    // one row query as driven on the request channel
    typedef struct {
        logic [COORD_BITS-1:0]  target_left;
        logic [COORD_BITS-1:0]  target_top;
        logic [COORD_BITS-1:0]  target_right;
        logic [COORD_BITS-1:0]  target_bottom;
        logic [COORD_BITS-1:0]  clip_left;
        logic [COORD_BITS-1:0]  clip_top;
        logic [COORD_BITS-1:0]  clip_right;
        logic [COORD_BITS-1:0]  clip_bottom;
        logic [RADIUS_BITS-1:0] corner_radius;
        logic [COLOR_BITS-1:0]  color_rgb;
        logic [COORD_BITS-1:0]  row;
    } t_row_query;

    // one span as returned on the result channel
    typedef struct {
        logic                  draw;
        logic [COORD_BITS-1:0] span_start;
        logic [COORD_BITS-1:0] span_end;
        logic [PIXEL_BITS-1:0] pixel;
    } t_span;

    localparam int COORD_MAX  = (1 << COORD_BITS) - 1;
    localparam int RADIUS_MAX = (1 << RADIUS_BITS) - 1;
    localparam int COLOR_MAX  = (1 << COLOR_BITS) - 1;
    localparam int DRAIN_CYCLES = 40;

    logic  i_clk;
    logic  i_rst_n;
    t_span expected_spans[$];
    int    error_count = 0;
    int    send_idle_pct = 17;
    int    recv_idle_pct = 86;

    rrsf_in_if  span_req ();
    rrsf_out_if span_rsp ();

    rounded_rect_span_fill u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (span_req),
        .o_out   (span_rsp)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // overall time limit
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // largest half-width on arc row y, stepping down from rx
    function automatic int arc_half_width(int rx, int ry, int y);
        longint unsigned a;
        longint unsigned b;
        longint unsigned c;
        longint unsigned limit;
        longint unsigned y_term;
        int m;
        a = longint'(rx);
        b = longint'(ry);
        c = longint'(y);
        limit  = a * a * b * b + ((a * a * b) >> 1);
        y_term = a * a * c * c;
        m = rx;
        while (m > 0 && y_term + b * b * longint'(m) * longint'(m) > limit)
            m--;
        return m;
    endfunction

    // expected span and pixel for one row query
    function automatic t_span predict_span(t_row_query q);
        int tl, tt, tr, tb, cl, ct, cr, cb, rad, row;
        int w, h, cx, cy, rx, ry, dx, dy, ex, fy, yu, yl, y, m, s, e;
        t_span res;
        tl = int'(q.target_left);
        tt = int'(q.target_top);
        tr = int'(q.target_right);
        tb = int'(q.target_bottom);
        cl = int'(q.clip_left);
        ct = int'(q.clip_top);
        cr = int'(q.clip_right);
        cb = int'(q.clip_bottom);
        rad = int'(q.corner_radius);
        row = int'(q.row);
        s = 0;
        e = 0;
        if (row >= ct && row < cb) begin
            if (rad == 0) begin
                s = cl;
                e = cr;
            end else begin
                w = (tr >= tl) ? tr - tl : 0;
                h = (tb >= tt) ? tb - tt : 0;
                cx = tl + w / 2;
                cy = tt + h / 2;
                // radius limited to half the extent
                if (rad * 2 <= h) begin
                    ry = rad;
                    dy = cy - tt - ry;
                end else begin
                    ry = h >> 1;
                    dy = 0;
                end
                if (rad * 2 <= w) begin
                    rx = rad;
                    dx = cx - tl - rx;
                end else begin
                    rx = w >> 1;
                    dx = 0;
                end
                ex = w % 2;
                fy = (h % 2 == 0) ? 1 : 0;
                if (row >= cy - dy && row <= cy + dy) begin
                    s = cl;
                    e = cr;
                end else begin
                    // upper arc first, then lower arc
                    yu = cy - dy - row;
                    yl = row - (cy + dy - fy);
                    y = 0;
                    if (yu >= 1 && yu <= ry)
                        y = yu;
                    else if (yl >= 1 && yl <= ry)
                        y = yl;
                    if (y != 0) begin
                        m = arc_half_width(rx, ry, y);
                        s = cx - m - dx;
                        e = cx + m + dx + ex;
                        if (s < cl) s = cl;
                        if (e > cr) e = cr;
                    end
                end
            end
        end
        if (s >= e) begin
            s = 0;
            e = 0;
        end
        res.draw       = (s < e);
        res.span_start = s[COORD_BITS-1:0];
        res.span_end   = e[COORD_BITS-1:0];
        res.pixel      = {q.color_rgb[23:19], q.color_rgb[15:10], q.color_rgb[7:3]};
        return res;
    endfunction

    function automatic t_row_query make_query(int tl, int tt, int tr, int tb,
                                              int cl, int ct, int cr, int cb,
                                              int rad, int rgb, int row);
        t_row_query q;
        q.target_left   = COORD_BITS'(tl);
        q.target_top    = COORD_BITS'(tt);
        q.target_right  = COORD_BITS'(tr);
        q.target_bottom = COORD_BITS'(tb);
        q.clip_left     = COORD_BITS'(cl);
        q.clip_top      = COORD_BITS'(ct);
        q.clip_right    = COORD_BITS'(cr);
        q.clip_bottom   = COORD_BITS'(cb);
        q.corner_radius = RADIUS_BITS'(rad);
        q.color_rgb     = COLOR_BITS'(rgb);
        q.row           = COORD_BITS'(row);
        return q;
    endfunction

    function automatic int clamp_coord(int v);
        if (v < 0) return 0;
        if (v > COORD_MAX) return COORD_MAX;
        return v;
    endfunction

    // one request transfer, with random gaps in front of it
    task automatic send_query(input t_row_query q);
        while ($urandom_range(99) < send_idle_pct) begin
            span_req.valid <= 1'b0;
            @(posedge i_clk);
        end
        span_req.valid         <= 1'b1;
        span_req.target_left   <= q.target_left;
        span_req.target_top    <= q.target_top;
        span_req.target_right  <= q.target_right;
        span_req.target_bottom <= q.target_bottom;
        span_req.clip_left     <= q.clip_left;
        span_req.clip_top      <= q.clip_top;
        span_req.clip_right    <= q.clip_right;
        span_req.clip_bottom   <= q.clip_bottom;
        span_req.corner_radius <= q.corner_radius;
        span_req.color_rgb     <= q.color_rgb;
        span_req.row           <= q.row;
        do @(posedge i_clk); while (!span_req.ready);
        expected_spans.push_back(predict_span(q));
    endtask

    // hold off the request side until every span is back
    task automatic wait_for_drain();
        span_req.valid <= 1'b0;
        do @(posedge i_clk); while (expected_spans.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // result side: random ready, compare each transfer with the oldest prediction
    always @(posedge i_clk) begin : span_checker
        t_span want;
        if (i_rst_n && span_rsp.valid && span_rsp.ready) begin
            if (expected_spans.size() == 0) begin
                $display("%0t: unexpected span, expected none, actual draw %0d %0d..%0d %0h",
                         $time, span_rsp.draw, span_rsp.span_start, span_rsp.span_end,
                         span_rsp.pixel);
                error_count++;
            end else begin
                want = expected_spans.pop_front();
                check_field("draw", 16'(want.draw), 16'(span_rsp.draw));
                check_field("span_start", 16'(want.span_start), 16'(span_rsp.span_start));
                check_field("span_end", 16'(want.span_end), 16'(span_rsp.span_end));
                check_field("pixel", want.pixel, span_rsp.pixel);
            end
        end
        span_rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // zero radius fills the clip width on clip rows only
    task automatic test_plain_fill();
        send_query(make_query(10, 10, 50, 50, 0, 0, COORD_MAX, COORD_MAX, 0, COLOR_MAX, 20));
        send_query(make_query(10, 10, 50, 50, 100, 5, 200, 9, 0, 24'h123456, 5));
        send_query(make_query(10, 10, 50, 50, 100, 5, 200, 9, 0, 0, 9));
    endtask

    // inverted target, inverted or empty clip, flat target
    task automatic test_degenerate_shapes();
        send_query(make_query(100, 10, 50, 30, 0, 0, COORD_MAX, COORD_MAX, 4, 24'hFF0000, 20));
        send_query(make_query(100, 10, 50, 30, 0, 0, COORD_MAX, COORD_MAX, 4, 24'hFF0000, 16));
        send_query(make_query(10, 80, 60, 40, 0, 0, COORD_MAX, COORD_MAX, 6, 24'h00FF00, 80));
        send_query(make_query(10, 10, 60, 40, 200, 0, 100, COORD_MAX, 0, 24'h0000FF, 20));
        send_query(make_query(10, 10, 60, 40, 0, 25, COORD_MAX, 25, 3, 24'h0000FF, 25));
        send_query(make_query(20, 50, 90, 50, 30, 0, 70, COORD_MAX, 5, 24'h808080, 50));
        send_query(make_query(20, 50, 90, 50, 30, 0, 70, COORD_MAX, 5, 24'h808080, 51));
    endtask

    // upper arc, middle, lower arc meeting the middle row, clipped arcs
    task automatic test_arc_rows();
        int arc_rows[8] = '{199, 200, 204, 207, 222, 225, 229, 230};
        foreach (arc_rows[i])
            send_query(make_query(100, 200, 140, 230, 0, 0, COORD_MAX, COORD_MAX,
                                  8, 24'hA5C3E7, arc_rows[i]));
        send_query(make_query(100, 200, 141, 241, 0, 0, COORD_MAX, COORD_MAX, 20, 24'h5A3C7E,
                              201));
        send_query(make_query(100, 200, 141, 241, 105, 0, 130, COORD_MAX, 20, 24'h5A3C7E,
                              240));
        send_query(make_query(0, 0, COORD_MAX, COORD_MAX, 1000, 0, 3000, COORD_MAX,
                              RADIUS_MAX, 24'h010203, 0));
    endtask

    // every field at its bounds
    task automatic test_field_extremes();
        send_query(make_query(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                              COORD_MAX, COORD_MAX, COORD_MAX, RADIUS_MAX, COLOR_MAX,
                              COORD_MAX));
        send_query(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_query(make_query(0, 0, COORD_MAX, COORD_MAX, 0, 0, COORD_MAX, COORD_MAX,
                              RADIUS_MAX, COLOR_MAX, COORD_MAX - 1));
    endtask

    // mostly well-formed rectangles with rows across and just outside the target, some pure noise
    task automatic send_random_query();
        t_row_query q;
        int w, h, tl, tt, rad, pick;
        pick = $urandom_range(99);
        if (pick < 15) begin
            q = make_query($urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                           $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                           $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                           $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                           $urandom_range(RADIUS_MAX), $urandom_range(COLOR_MAX),
                           $urandom_range(COORD_MAX));
        end else begin
            if ($urandom_range(9) == 0) begin
                w = $urandom_range(COORD_MAX);
                h = $urandom_range(COORD_MAX);
            end else begin
                w = $urandom_range(64);
                h = $urandom_range(64);
            end
            tl = $urandom_range(COORD_MAX - w);
            tt = $urandom_range(COORD_MAX - h);
            case ($urandom_range(9))
                0: rad = 0;
                1: rad = $urandom_range(RADIUS_MAX);
                2: rad = (((w > h) ? w : h) / 2) + int'($urandom_range(1, 8));
                default: rad = $urandom_range(1, 16);
            endcase
            if (rad > RADIUS_MAX) rad = RADIUS_MAX;
            q = make_query(tl, tt, tl + w, tt + h, 0, 0, COORD_MAX, COORD_MAX, rad,
                           $urandom_range(COLOR_MAX),
                           clamp_coord(tt + int'($urandom_range(h + 3)) - 2));
            // full clip, clip around the target edges, or clip anywhere
            case ($urandom_range(3))
                0: ;
                1, 2: begin
                    q.clip_left   = COORD_BITS'(clamp_coord(tl + int'($urandom_range(16)) - 8));
                    q.clip_right  = COORD_BITS'(clamp_coord(tl + w +
                                                            int'($urandom_range(16)) - 8));
                    q.clip_top    = COORD_BITS'(clamp_coord(tt + int'($urandom_range(16)) - 8));
                    q.clip_bottom = COORD_BITS'(clamp_coord(tt + h +
                                                            int'($urandom_range(16)) - 8));
                end
                default: begin
                    q.clip_left   = COORD_BITS'($urandom_range(COORD_MAX));
                    q.clip_right  = COORD_BITS'($urandom_range(COORD_MAX));
                    q.clip_top    = COORD_BITS'($urandom_range(COORD_MAX));
                    q.clip_bottom = COORD_BITS'($urandom_range(COORD_MAX));
                end
            endcase
        end
        send_query(q);
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int count, input bit pause_midway);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < count; i++) begin
            if (pause_midway && i == count / 2)
                wait_for_drain();
            send_random_query();
        end
    endtask

    // reset, then each test in turn
    initial begin
        i_rst_n                = 1'b0;
        span_req.valid         = 1'b0;
        span_req.target_left   = '0;
        span_req.target_top    = '0;
        span_req.target_right  = '0;
        span_req.target_bottom = '0;
        span_req.clip_left     = '0;
        span_req.clip_top      = '0;
        span_req.clip_right    = '0;
        span_req.clip_bottom   = '0;
        span_req.corner_radius = '0;
        span_req.color_rgb     = '0;
        span_req.row           = '0;
        span_rsp.ready         = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_plain_fill();
        test_degenerate_shapes();
        test_arc_rows();
        test_field_extremes();
        test_random_traffic(17, 86, 310, 1'b1);
        test_random_traffic(86, 17, 310, 1'b0);
        test_random_traffic(0, 0, 310, 1'b0);

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
